// File: rtl/spdg_pkg.sv
// Package for the dense-graph shortest path block: sizes, types and codes.
// Used by every module in rtl/; depends on nothing.
package spdg_pkg;
	localparam int MaxVertices = 16;
	localparam int VtxBits     = 4;
	localparam int WeightBits  = 16;
	localparam int CostBits    = 24;
	localparam int CountBits   = 5;
	localparam int EdgeAddrBits = 2 * VtxBits;
	localparam int QueueDepth  = 4;
	localparam int QueuePtrBits = 2;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [VtxBits-1:0]    vtx_t;
	typedef logic [CostBits-1:0]   cost_t;
	typedef logic [WeightBits-1:0] weight_t;

	typedef struct packed {
		logic    cmd;
		vtx_t    src;
		vtx_t    dst;
		weight_t weight;
		logic    edge_present;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_INIT_W,
		ST_SCAN,
		ST_SELECT,
		ST_RELAX,
		ST_RELAX_W,
		ST_TRACE,
		ST_EMIT,
		ST_FAIL
	} state_t;
endpackage

// File: rtl/spdg_front.sv
// Front end: accepts items and holds them in a short queue for the engine.
// Depends on spdg_pkg.
module spdg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  spdg_pkg::item_t in_item,
	output logic          q_valid,
	output spdg_pkg::item_t q_item,
	input  logic          q_take
);
	import spdg_pkg::*;

	item_t                mem_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_q, rd_q;
	logic [QueuePtrBits:0]   cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (QueuePtrBits+1)'(QueueDepth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != '0;
	assign pop      = q_valid && q_take;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrBits+1)'(push) - (QueuePtrBits+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QueuePtrBits+1)'(QueueDepth)) else $error("queue overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("pop from empty queue");
`endif
endmodule

// File: rtl/spdg_engine.sv
// Back end: edge matrix memory and the Dijkstra sequencer with path output.
// Depends on spdg_pkg.
module spdg_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  spdg_pkg::item_t q_item,
	output logic          q_take,
	input  logic [spdg_pkg::CountBits-1:0] n_cfg,
	output logic          out_valid,
	input  logic          out_stall,
	output spdg_pkg::vtx_t  o_vertex,
	output spdg_pkg::cost_t o_cost,
	output logic          o_reach,
	output logic          o_last
);
	import spdg_pkg::*;

	localparam int Cells = MaxVertices * MaxVertices;
	localparam logic [CostBits:0] CMax = {1'b0, {CostBits{1'b1}}};

	weight_t w_mem [Cells];
	weight_t rd_w_q;
	logic [Cells-1:0] ev_q;

	cost_t dist_q [MaxVertices];
	vtx_t  pred_q [MaxVertices];
	logic [MaxVertices-1:0] settled_q, reached_q;
	vtx_t  path_q [MaxVertices];

	state_t st_q, st_d;
	item_t  cur_q;
	logic [CountBits-1:0] n_q;
	logic [VtxBits-1:0] i_q, v_q, best_q, trace_q;
	logic found_q;
	logic [CountBits-1:0] plen_q, emit_q;

	// combinational control
	logic [EdgeAddrBits-1:0] raddr;
	logic rd_en, i_end;
	logic [CostBits:0] sum;
	cost_t nd;

	assign i_end = ({1'b0, i_q} == n_q - 1'b1);
	assign sum = {1'b0, dist_q[v_q]} + {{(CostBits-WeightBits+1){1'b0}}, rd_w_q};
	assign nd  = (sum > CMax) ? CMax[CostBits-1:0] : sum[CostBits-1:0];

	always_comb begin
		st_d   = st_q;
		q_take = 1'b0;
		rd_en  = 1'b0;
		raddr  = {v_q, i_q};
		case (st_q)
			ST_IDLE:    if (q_valid) begin
				q_take = 1'b1;
				if (q_item.cmd == CMD_QUERY) st_d = ST_INIT;
			end
			ST_INIT:    begin
				if ({1'b0, cur_q.src} >= n_q || {1'b0, cur_q.dst} >= n_q) st_d = ST_FAIL;
				else if (cur_q.src == cur_q.dst) st_d = ST_TRACE;
				else begin
					rd_en = 1'b1;
					raddr = {cur_q.src, i_q};
					st_d  = ST_INIT_W;
				end
			end
			ST_INIT_W:  begin
				if (i_end) st_d = ST_SCAN;
				else begin
					rd_en = 1'b1;
					raddr = {cur_q.src, i_q + 1'b1};
				end
			end
			ST_SCAN:    if (i_end) st_d = ST_SELECT;
			ST_SELECT:  begin
				if (!found_q) st_d = ST_FAIL;
				else if (best_q == cur_q.dst) st_d = ST_TRACE;
				else begin
					rd_en = 1'b1;
					raddr = {best_q, {VtxBits{1'b0}}};
					st_d  = ST_RELAX_W;
				end
			end
			ST_RELAX_W: begin
				if (i_end) st_d = ST_SCAN;
				else begin
					rd_en = 1'b1;
					raddr = {v_q, i_q + 1'b1};
				end
			end
			ST_TRACE:   if (trace_q == cur_q.src || plen_q >= n_q ||
				plen_q == CountBits'(MaxVertices)) st_d = ST_EMIT;
			ST_EMIT:    if (!out_stall && emit_q == CountBits'(1)) st_d = ST_IDLE;
			ST_FAIL:    if (!out_stall) st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && q_item.cmd == CMD_EDGE && q_item.edge_present)
			w_mem[{q_item.src, q_item.dst}] <= q_item.weight;
		if (rd_en) rd_w_q <= w_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ev_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE && q_valid && q_item.cmd == CMD_EDGE)
				ev_q[{q_item.src, q_item.dst}] <= q_item.edge_present;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE:    begin
				cur_q <= q_item;
				n_q   <= (n_cfg > CountBits'(MaxVertices)) ? CountBits'(MaxVertices) : n_cfg;
				i_q   <= '0;
			end
			ST_INIT:    begin
				settled_q <= '0;
				trace_q   <= cur_q.dst;
				path_q[0] <= cur_q.dst;
				plen_q    <= CountBits'(1);
				v_q       <= cur_q.src;
			end
			ST_INIT_W:  begin
				reached_q[i_q] <= ev_q[{cur_q.src, i_q}] || i_q == cur_q.src;
				dist_q[i_q]    <= (i_q == cur_q.src) ? '0 : CostBits'(rd_w_q);
				pred_q[i_q]    <= cur_q.src;
				if (i_q == cur_q.src) settled_q[i_q] <= 1'b1;
				i_q     <= i_end ? '0 : i_q + 1'b1;
				found_q <= 1'b0;
			end
			ST_SCAN:    begin
				if (!settled_q[i_q] && reached_q[i_q] &&
					(!found_q || dist_q[i_q] < dist_q[best_q])) begin
					best_q  <= i_q;
					found_q <= 1'b1;
				end
				i_q <= i_end ? '0 : i_q + 1'b1;
			end
			ST_SELECT:  begin
				v_q <= best_q;
				settled_q[best_q] <= 1'b1;
				i_q <= '0;
			end
			ST_RELAX_W: begin
				if (!settled_q[i_q] && ev_q[{v_q, i_q}] &&
					(!reached_q[i_q] || nd < dist_q[i_q])) begin
					dist_q[i_q]    <= nd;
					pred_q[i_q]    <= v_q;
					reached_q[i_q] <= 1'b1;
				end
				i_q     <= i_end ? '0 : i_q + 1'b1;
				found_q <= 1'b0;
			end
			ST_TRACE:   begin
				if (cur_q.src == cur_q.dst) begin
					path_q[0] <= cur_q.dst;
					plen_q    <= CountBits'(1);
					emit_q    <= CountBits'(1);
					dist_q[cur_q.dst] <= '0;
				end else if (st_d == ST_EMIT) begin
					emit_q <= plen_q;
				end else begin
					trace_q <= pred_q[trace_q];
					path_q[plen_q[VtxBits-1:0]] <= pred_q[trace_q];
					plen_q  <= plen_q + 1'b1;
				end
			end
			ST_EMIT:    if (!out_stall) emit_q <= emit_q - 1'b1;
			default:    ;
		endcase
	end

	assign out_valid = (st_q == ST_EMIT) || (st_q == ST_FAIL);
	assign o_last    = (st_q == ST_FAIL) || emit_q == CountBits'(1);
	assign o_reach   = (st_q == ST_EMIT);
	always_comb begin
		logic [CountBits-1:0] k;
		k = emit_q - 1'b1;
		o_vertex = (st_q == ST_EMIT) ? path_q[k[VtxBits-1:0]] : '0;
		o_cost   = (st_q == ST_EMIT && o_last) ? dist_q[cur_q.dst] : '0;
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> st_q == ST_IDLE) else $error("item taken while busy");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT && out_stall |=> st_q == ST_EMIT && $stable(emit_q))
		else $error("result moved while stalled");
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |-> emit_q != '0) else $error("empty path emitted");
`endif
endmodule

// File: rtl/shortest_path_dense_graph_top.sv
// Top level of the dense-graph shortest path block.
// Instantiates spdg_front and spdg_engine; depends on spdg_pkg.
//
// Usage. Items enter on in_valid/in_stall with fields cmd, src, dst, weight and
// edge_present; an item is taken at an edge with in_valid high and in_stall low.
// An edge-write item (cmd 0) is taken by the idle engine and gives no result.
// A query item (cmd 1) runs Dijkstra from src and then gives the path one
// vertex per result on out_valid/out_stall, source first; the final result has
// last set and carries path_cost. An unreachable query gives one result with
// reachable low.
// Operation. Each pass scans all distances once and relaxes one matrix row, one
// memory read a cycle, and the path is traced, then sent one result a cycle
// while the receiver does not stall. Items queue in a four-entry buffer
// meanwhile, so the sender can run ahead of the engine.
// The vertex_count register is written on cfg_valid/cfg_ready; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears all edges, sets vertex_count to 16 and empties the queue.
// When the receiver stalls, the current result holds and the engine waits.
module shortest_path_dense_graph_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [3:0]  src,
	input  logic [3:0]  dst,
	input  logic [15:0] weight,
	input  logic        edge_present,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  vertex,
	output logic [23:0] path_cost,
	output logic        reachable,
	output logic        last
);
	import spdg_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_take;
	logic [CountBits-1:0] vcount_q;

	// The register is always writable; the user must write it only while idle.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= CountBits'(MaxVertices);
		else if (cfg_valid) vcount_q <= cfg_data;
	end

	assign in_item = '{cmd: cmd, src: src, dst: dst, weight: weight,
		edge_present: edge_present};

	spdg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	spdg_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take), .n_cfg(vcount_q), .out_valid(out_valid),
		.out_stall(out_stall), .o_vertex(vertex), .o_cost(path_cost),
		.o_reach(reachable), .o_last(last)
	);
endmodule
